// File: design/canonical_huffman_table_builder_defines.svh
// assertion macros for the canonical huffman table builder
`ifndef CANONICAL_HUFFMAN_TABLE_BUILDER_DEFINES_SVH
`define CANONICAL_HUFFMAN_TABLE_BUILDER_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define CHTB_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`define CHTB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define CHTB_ASSERT_IMPL(lbl, ante, cons, msg)

`define CHTB_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// File: design/chtb_pkg.sv
// shared types and constants for the canonical huffman table builder
`default_nettype none

package chtb_pkg;

  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_LOOKUP = 1'b1;

  localparam logic [2:0] STATUS_OK       = 3'd0;
  localparam logic [2:0] STATUS_TOO_LONG = 3'd1;
  localparam logic [2:0] STATUS_TOO_MANY = 3'd2;
  localparam logic [2:0] STATUS_OVERSUB  = 3'd3;

  typedef struct packed {
    logic        mode;
    logic [3:0]  code_length;
    logic        last;
    logic [14:0] peek_bits;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [8:0] symbol;
    logic [3:0] symbol_length;
    logic       empty_res;
    logic [3:0] max_length;
  } rsp_t;

  typedef struct packed {
    logic       valid;
    logic [8:0] sym;
    logic [3:0] len;
  } tbl_entry_t;

endpackage

`default_nettype wire

// File: design/chtb_stream_if.sv
// valid/ready stream channel carrying one payload struct
`default_nettype none

interface chtb_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: design/canonical_huffman_table_builder.sv
// canonical huffman decode table builder: length loads, table build, lookups
// a load without last gives its result in the cycle after the request, a lookup after its
// table read in LOOK; a load with last runs the build: length count, Kraft check, first codes,
// a clear pass, then fill at one entry per cycle in FILL on the single table write port (a rejected set skips the fill)
// one request at a time, no new request while a build or lookup is under way
// rst is synchronous; the table is undefined until the first build completes
`default_nettype none
`include "canonical_huffman_table_builder_defines.svh"

module canonical_huffman_table_builder import chtb_pkg::*; #(
  parameter int MAX_SYMBOLS = 512,
  parameter int MAX_BITS    = 15
) (
  input  wire logic      clk,
  input  wire logic      rst,
  chtb_stream_if.sink    req,
  chtb_stream_if.source  rsp
);

  localparam int SW = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
  localparam int CW = $clog2(MAX_SYMBOLS + 1);
  localparam int TD = 1 << MAX_BITS;
  localparam int LW = ((MAX_BITS > CW) ? MAX_BITS : CW) + 3;

  typedef enum logic [3:0] {
    IDLE, LOOK, CNT, KRAFT, FIRST, CLR, FREAD, FWAIT, FILL, DONE
  } state_t;

  state_t                state;
  rsp_t                  out_data;
  logic                  out_valid;
  logic [CW-1:0]         symbol_count;
  logic [CW-1:0]         idx;
  logic [2:0]            status;
  logic [3:0]            longest;
  logic [CW-1:0]         count_len [16];
  logic [15:0]           len_code [16];
  logic signed [LW-1:0]  left;
  logic [4:0]            kl;
  logic [15:0]           code;
  logic                  pend;
  logic [3:0]            cur_len;
  logic [SW-1:0]         cur_sym;
  logic [MAX_BITS-1:0]   base;
  logic [MAX_BITS-1:0]   k;
  logic [MAX_BITS-1:0]   kmax;
  logic [MAX_BITS-1:0]   clr_idx;

  logic [3:0]            length_store [MAX_SYMBOLS];
  logic [3:0]            ls_rd;
  logic [SW-1:0]         ls_raddr;
  logic                  ls_we;

  tbl_entry_t            decode_table [TD];
  tbl_entry_t            tbl_rd;
  tbl_entry_t            tbl_wdata;
  logic [MAX_BITS-1:0]   tbl_waddr;
  logic [MAX_BITS-1:0]   tbl_raddr;
  logic                  tbl_we;

  logic                  req_fire;
  logic                  load_ack;
  logic                  full;
  logic [2:0]            st_base;
  logic [2:0]            st_load;
  logic [3:0]            cnt_addr;
  logic [CW-1:0]         cnt_rd;
  logic [15:0]           next_rd;
  logic signed [LW-1:0]  left_next;
  logic [15:0]           code_next;
  logic [MAX_BITS-1:0]   lmask;
  logic [3:0]            spare;
  logic [MAX_BITS-1:0]   masked;
  logic [MAX_BITS-1:0]   fill_val;
  logic [MAX_BITS-1:0]   fill_rev;
  logic [MAX_BITS-1:0]   fill_idx;

  assign req.ready = (state == IDLE) && (!out_valid || rsp.ready);
  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;
  assign req_fire  = req.valid && req.ready;
  assign load_ack  = req_fire && (req.data.mode == MODE_LOAD) && !req.data.last;

  // load status
  assign full = symbol_count >= CW'(MAX_SYMBOLS);
  always_comb begin
    st_base = (symbol_count == '0) ? STATUS_OK : status;
    st_load = st_base;
    if (st_base == STATUS_OK) begin
      if (full) begin
        st_load = STATUS_TOO_MANY;
      end else if (req.data.code_length > 4'(MAX_BITS)) begin
        st_load = STATUS_TOO_LONG;
      end
    end
  end

  // shared count port
  always_comb begin
    case (state)
      CNT:     cnt_addr = ls_rd;
      FIRST:   cnt_addr = kl[3:0] - 4'd1;
      default: cnt_addr = kl[3:0];
    endcase
  end
  assign cnt_rd    = count_len[cnt_addr];
  assign next_rd   = len_code[ls_rd];
  assign left_next = (left <<< 1) - $signed(LW'(cnt_rd));
  assign code_next = (code + 16'(cnt_rd)) << 1;

  assign lmask  = MAX_BITS'((32'd1 << longest) - 32'd1);
  assign spare  = longest - ls_rd;
  assign masked = MAX_BITS'(32'(next_rd) & ((32'd1 << ls_rd) - 32'd1));

  // bit-reversed table index of the current fill entry
  assign fill_val = base | k;
  always_comb begin
    for (int b = 0; b < MAX_BITS; b++) begin
      fill_rev[b] = fill_val[MAX_BITS-1-b];
    end
  end
  assign fill_idx = fill_rev >> (4'(MAX_BITS) - longest);

  assign ls_we    = req_fire && (req.data.mode == MODE_LOAD) && !full;
  assign ls_raddr = idx[SW-1:0];

  always_comb begin
    tbl_we    = 1'b0;
    tbl_waddr = clr_idx;
    tbl_wdata = '0;
    if (state == CLR) begin
      tbl_we = 1'b1;
    end else if (state == FILL) begin
      tbl_we          = 1'b1;
      tbl_waddr       = fill_idx;
      tbl_wdata.valid = 1'b1;
      tbl_wdata.sym   = 9'(cur_sym);
      tbl_wdata.len   = cur_len;
    end
  end
  assign tbl_raddr = req.data.peek_bits[MAX_BITS-1:0] & lmask;

  always_ff @(posedge clk) begin
    if (ls_we) begin
      length_store[symbol_count[SW-1:0]] <= req.data.code_length;
    end
    ls_rd <= length_store[ls_raddr];
  end

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      decode_table[tbl_waddr] <= tbl_wdata;
    end
    tbl_rd <= decode_table[tbl_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= IDLE;
      out_valid    <= 1'b0;
      symbol_count <= '0;
      status       <= STATUS_OK;
      longest      <= '0;
      pend         <= 1'b0;
    end else begin
      if (out_valid && rsp.ready && !load_ack) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (req_fire) begin
            if (req.data.mode == MODE_LOOKUP) begin
              state <= LOOK;
            end else begin
              status <= st_load;
              if (!full) begin
                symbol_count <= symbol_count + CW'(1);
              end
              if (req.data.last) begin
                longest <= '0;
                idx     <= '0;
                pend    <= 1'b0;
                clr_idx <= '0;
                for (int i = 0; i < 16; i++) begin
                  count_len[i] <= '0;
                end
                state <= (st_load != STATUS_OK) ? CLR : CNT;
              end else begin
                out_valid              <= 1'b1;
                out_data.status        <= st_load;
                out_data.symbol        <= '0;
                out_data.symbol_length <= '0;
                out_data.empty_res     <= 1'b0;
                out_data.max_length    <= longest;
              end
            end
          end
        end
        LOOK: begin
          out_valid              <= 1'b1;
          out_data.status        <= status;
          out_data.symbol        <= tbl_rd.valid ? tbl_rd.sym : '0;
          out_data.symbol_length <= tbl_rd.valid ? tbl_rd.len : '0;
          out_data.empty_res     <= !tbl_rd.valid;
          out_data.max_length    <= longest;
          state                  <= IDLE;
        end
        CNT: begin
          if (pend && (ls_rd != '0)) begin
            count_len[ls_rd] <= cnt_rd + CW'(1);
            if (ls_rd > longest) begin
              longest <= ls_rd;
            end
          end
          if (idx < symbol_count) begin
            idx  <= idx + CW'(1);
            pend <= 1'b1;
          end else begin
            pend <= 1'b0;
            if (!pend) begin
              kl    <= 5'd1;
              left  <= LW'(1);
              state <= KRAFT;
            end
          end
        end
        KRAFT: begin
          if (kl > {1'b0, longest}) begin
            kl    <= 5'd1;
            code  <= '0;
            state <= FIRST;
          end else if (left_next < 0) begin
            status  <= STATUS_OVERSUB;
            longest <= '0;
            clr_idx <= '0;
            state   <= CLR;
          end else begin
            left <= left_next;
            kl   <= kl + 5'd1;
          end
        end
        FIRST: begin
          if (kl > {1'b0, longest}) begin
            clr_idx <= '0;
            state   <= CLR;
          end else begin
            len_code[kl[3:0]] <= code_next;
            code              <= code_next;
            kl                <= kl + 5'd1;
          end
        end
        CLR: begin
          if (clr_idx == lmask) begin
            idx   <= '0;
            state <= (status != STATUS_OK) ? DONE : FREAD;
          end else begin
            clr_idx <= clr_idx + MAX_BITS'(1);
          end
        end
        FREAD: begin
          if (idx < symbol_count) begin
            cur_sym <= idx[SW-1:0];
            idx     <= idx + CW'(1);
            state   <= FWAIT;
          end else begin
            state <= DONE;
          end
        end
        FWAIT: begin
          if (ls_rd == '0) begin
            state <= FREAD;
          end else begin
            cur_len         <= ls_rd;
            base            <= MAX_BITS'(masked << spare);
            kmax            <= MAX_BITS'((32'd1 << spare) - 32'd1);
            k               <= '0;
            len_code[ls_rd] <= next_rd + 16'd1;
            state           <= FILL;
          end
        end
        FILL: begin
          if (k == kmax) begin
            state <= FREAD;
          end else begin
            k <= k + MAX_BITS'(1);
          end
        end
        DONE: begin
          out_valid              <= 1'b1;
          out_data.status        <= status;
          out_data.symbol        <= '0;
          out_data.symbol_length <= '0;
          out_data.empty_res     <= 1'b0;
          out_data.max_length    <= longest;
          symbol_count           <= '0;
          state                  <= IDLE;
        end
        default: state <= IDLE;
      endcase
    end
  end

  `CHTB_ASSERT_IMPL(a_ready_idle, req.ready, state == IDLE && (!out_valid || rsp.ready), "request taken outside idle or with output blocked")
  `CHTB_ASSERT_NEXT(a_lookup_read, req_fire && req.data.mode == MODE_LOOKUP, state == LOOK && !out_valid, "lookup did not go to table read")
  `CHTB_ASSERT_IMPL(a_fill_ok, state == FILL || state == FWAIT, status == STATUS_OK, "table fill on a rejected set")
  `CHTB_ASSERT_IMPL(a_build_quiet, state == CNT || state == KRAFT || state == FIRST, !out_valid, "result shown during build")

endmodule

`default_nettype wire
